[rtl/assert_macros.svh]
// Assertion macros used by the checker module of the block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge of clk while rst_n is high.
`define SCDXT1_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("scdxt1 assertion failed");

// Check that cons holds in the cycle after ante.
`define SCDXT1_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scdxt1 assertion failed");

`endif

[rtl/scdxt1_pkg.sv]
// Shared types, constants and helper functions of the single-color DXT1 encoder.
// Depends on nothing; used by the channel quantizer, top level and checker.
`default_nettype none

package scdxt1_pkg;

	localparam int unsigned NUM_CHAN = 3;

	localparam logic [3:0] WEIGHT_FULL = 4'd12;
	localparam logic [16:0] ENDPOINT_MAX = 17'h0FFFF;

	localparam logic [3:0] IDX_CODE_0 = 4'd0;
	localparam logic [3:0] IDX_CODE_1 = 4'd5;
	localparam logic [3:0] IDX_CODE_2 = 4'd10;
	localparam logic [3:0] IDX_CODE_3 = 4'd15;

	typedef struct packed {
		logic [23:0] color_rgb;
		logic        three_color_mode;
	} in_payload_t;

	typedef struct packed {
		logic [31:0] endpoint_word;
		logic [31:0] index_word;
		logic [3:0]  blend_weight;
		logic [3:0]  index_code;
	} out_payload_t;

	// Quantized channel: 565 level, distance above its expansion, wide step flag
	typedef struct packed {
		logic [5:0] base;
		logic [3:0] diff;
		logic       long_step;
	} chan_quant_t;

	// Position in twelfths between two adjacent levels
	function automatic logic [5:0] chan_pos(input logic [3:0] diff, input logic green,
			input logic long_step);
		logic [7:0] num;
		logic [13:0] prod9;
		logic [15:0] prod5;
		logic [5:0] pos;
		begin
			num   = {4'b0, diff} * 8'd12;
			prod9 = 14'(num) * 14'd57;
			prod5 = 16'(num) * 16'd205;
			unique case ({green, long_step})
				2'b00: pos = 6'(num >> 3);
				2'b01: pos = 6'(prod9 >> 9);
				2'b10: pos = 6'(num >> 2);
				2'b11: pos = 6'(prod5 >> 10);
				default: pos = '0;
			endcase
			return pos;
		end
	endfunction

endpackage

`default_nettype wire

[rtl/scdxt1_in_if.sv]
// Request channel carrying one source color and its mode bit.
// Depends on nothing.
`default_nettype none

interface scdxt1_in_if;
	logic        valid;
	logic        ready;
	logic [23:0] color_rgb;
	logic        three_color_mode;

	modport source (output valid, output color_rgb, output three_color_mode, input ready);
	modport sink (input valid, input color_rgb, input three_color_mode, output ready);
endinterface

`default_nettype wire

[rtl/scdxt1_out_if.sv]
// Result channel carrying one encoded DXT1 block.
// Depends on nothing.
`default_nettype none

interface scdxt1_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] endpoint_word;
	logic [31:0] index_word;
	logic [3:0]  blend_weight;
	logic [3:0]  index_code;

	modport source (output valid, output endpoint_word, output index_word,
		output blend_weight, output index_code, input ready);
	modport sink (input valid, input endpoint_word, input index_word,
		input blend_weight, input index_code, output ready);
endinterface

`default_nettype wire

[rtl/scdxt1_chan_quant.sv]
// Quantizes one 8-bit channel to its 5- or 6-bit level and measures the remainder.
// Depends on scdxt1_pkg.
`default_nettype none

module scdxt1_chan_quant (
	input  wire logic [7:0]               ch,
	input  wire logic                     green,
	output scdxt1_pkg::chan_quant_t       quant
);

	logic [7:0] red_adj;
	logic [4:0] red_base;
	logic [7:0] red_q;
	logic [7:0] grn_adj;
	logic [5:0] grn_base;
	logic [7:0] grn_q;
	logic [7:0] q;

	always_comb begin
		red_adj  = ch - (ch >> 5);
		red_base = red_adj[7:3];
		red_q    = {red_base, 3'b000} + {5'b0, red_base[4:2]};

		grn_adj  = ch - (ch >> 6);
		grn_base = grn_adj[7:2];
		grn_q    = {grn_base, 2'b00} + {6'b0, grn_base[5:4]};

		if (green) begin
			q               = grn_q;
			quant.base      = grn_base;
			quant.long_step = (grn_base[3:0] == 4'hF);
		end else begin
			q               = red_q;
			quant.base      = {1'b0, red_base};
			quant.long_step = (red_base[1:0] == 2'b11);
		end
		quant.diff = 4'(ch - q);
	end

endmodule

`default_nettype wire

[rtl/single_color_dxt1_block_encoder.sv]
// Top level of the single-color DXT1 block encoder: four-stage pipeline with an
// output register and skid buffer. Depends on scdxt1_pkg, the channel interfaces
// and scdxt1_chan_quant.
//
// One color request enters per cycle while ready is high. Its block passes through the
// stage 1, 2 and 3 registers into the output register; sustained rate is one block per
// cycle while the result side takes them. The stages are channel quantization, endpoint
// selection and scoring, weight averaging, and ordering with index selection. The result
// side has a two-entry buffer, so ready drops only when both entries hold untaken blocks,
// and then the whole pipeline holds in place.
`default_nettype none

module single_color_dxt1_block_encoder (
	input  wire logic   clk,
	input  wire logic   arst_n,
	scdxt1_in_if.sink   color,
	scdxt1_out_if.source block
);

	logic en;
	logic push;
	logic pop;

	// stage 1
	scdxt1_pkg::chan_quant_t quant [scdxt1_pkg::NUM_CHAN];
	scdxt1_pkg::chan_quant_t quant_s1 [scdxt1_pkg::NUM_CHAN];
	logic mode_s1;
	logic v_s1;

	// stage 2
	logic [5:0] pos [scdxt1_pkg::NUM_CHAN];
	logic [6:0] lo [scdxt1_pkg::NUM_CHAN];
	logic [6:0] hi [scdxt1_pkg::NUM_CHAN];
	logic [6:0] lvl [scdxt1_pkg::NUM_CHAN];
	logic [5:0] score;
	logic [1:0] cnt;
	logic [16:0] e1;
	logic [16:0] e2;
	logic [16:0] e1_s2;
	logic [16:0] e2_s2;
	logic [5:0] score_s2;
	logic [1:0] cnt_s2;
	logic mode_s2;
	logic v_s2;

	// stage 3
	logic [6:0] rounded;
	logic [14:0] prod3;
	logic [3:0] avg;
	logic sw;
	logic [16:0] e1_s3;
	logic [16:0] e2_s3;
	logic [3:0] avg_s3;
	logic [1:0] cnt_s3;
	logic sw_s3;
	logic v_s3;

	// stage 4
	logic [16:0] f1;
	logic [16:0] f2;
	logic [16:0] tmp;
	logic [3:0] wgt;
	logic [3:0] code;
	scdxt1_pkg::out_payload_t res;
	scdxt1_pkg::out_payload_t out_q;
	scdxt1_pkg::out_payload_t skid_q;
	logic out_v_q;
	logic skid_v_q;

	assign en          = !skid_v_q;
	assign color.ready = en;
	assign push        = en && v_s3;
	assign pop         = out_v_q && block.ready;

	for (genvar i = 0; i < scdxt1_pkg::NUM_CHAN; i++) begin : g_chan
		scdxt1_chan_quant u_quant (
			.ch    (color.color_rgb[8*i +: 8]),
			.green (1'(i == 1)),
			.quant (quant[i])
		);
	end

	always_comb begin
		score = '0;
		cnt   = '0;
		for (int i = 0; i < scdxt1_pkg::NUM_CHAN; i++) begin
			pos[i] = scdxt1_pkg::chan_pos(quant_s1[i].diff, 1'(i == 1),
				quant_s1[i].long_step);
			lvl[i] = {1'b0, quant_s1[i].base};
			if (pos[i] < 6'd2) begin
				lo[i] = lvl[i];
				hi[i] = lvl[i];
			end else if (pos[i] < 6'd6) begin
				lo[i] = lvl[i];
				hi[i] = lvl[i] + 7'd1;
			end else if (pos[i] < 6'd10) begin
				lo[i] = lvl[i] + 7'd1;
				hi[i] = lvl[i];
			end else begin
				lo[i] = lvl[i] + 7'd1;
				hi[i] = lvl[i] + 7'd1;
			end
			if (lo[i] != hi[i]) begin
				score = score + ((lo[i] == lvl[i]) ? pos[i] : (6'd12 - pos[i]));
				cnt   = cnt + 2'd1;
			end
		end
		e1 = 17'(lo[0]) | (17'(lo[1]) << 5) | (17'(lo[2]) << 11);
		e2 = 17'(hi[0]) | (17'(hi[1]) << 5) | (17'(hi[2]) << 11);
	end

	always_comb begin
		rounded = 7'(score_s2) + 7'(cnt_s2 >> 1);
		prod3   = 15'(rounded) * 15'd171;
		unique case (cnt_s2)
			2'd0: avg = '0;
			2'd1: avg = 4'(rounded);
			2'd2: avg = 4'(rounded >> 1);
			2'd3: avg = 4'(prod3 >> 9);
			default: avg = '0;
		endcase
		sw = mode_s2 && (avg == 4'd5 || avg == 4'd6 || cnt_s2 == 2'd0);
	end

	always_comb begin
		f1  = e1_s3;
		f2  = e2_s3;
		wgt = avg_s3;
		if (cnt_s3 == 2'd0 && !sw_s3) begin
			if (f2 != scdxt1_pkg::ENDPOINT_MAX) begin
				wgt = '0;
				f2  = f2 + 17'd1;
			end else begin
				wgt = scdxt1_pkg::WEIGHT_FULL;
				f1  = f1 - 17'd1;
			end
		end
		tmp = f1;
		if ((f1 < f2) != sw_s3) begin
			f1  = f2;
			f2  = tmp;
			wgt = scdxt1_pkg::WEIGHT_FULL - wgt;
		end
		priority if (sw_s3)
			code = scdxt1_pkg::IDX_CODE_2;
		else if (wgt < 4'd2)
			code = scdxt1_pkg::IDX_CODE_0;
		else if (wgt < 4'd6)
			code = scdxt1_pkg::IDX_CODE_2;
		else if (wgt < 4'd10)
			code = scdxt1_pkg::IDX_CODE_3;
		else
			code = scdxt1_pkg::IDX_CODE_1;
		res.endpoint_word = {f2[15:0], f1[15:0]};
		res.index_word    = {8{code}};
		res.blend_weight  = wgt;
		res.index_code    = code;
	end

	// advance valid bits only while the result buffer has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= color.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quant_s1 <= quant;
			mode_s1  <= color.three_color_mode;
			e1_s2    <= e1;
			e2_s2    <= e2;
			score_s2 <= score;
			cnt_s2   <= cnt;
			mode_s2  <= mode_s1;
			e1_s3    <= e1_s2;
			e2_s3    <= e2_s2;
			avg_s3   <= avg;
			cnt_s3   <= cnt_s2;
			sw_s3    <= sw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop)
				skid_v_q <= 1'b0;
		end else if (push) begin
			if (!out_v_q || pop)
				out_v_q <= 1'b1;
			else
				skid_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop)
				out_q <= skid_q;
		end else if (push) begin
			if (!out_v_q || pop)
				out_q <= res;
			else
				skid_q <= res;
		end
	end

	assign block.valid         = out_v_q;
	assign block.endpoint_word = out_q.endpoint_word;
	assign block.index_word    = out_q.index_word;
	assign block.blend_weight  = out_q.blend_weight;
	assign block.index_code    = out_q.index_code;

endmodule

`default_nettype wire

[rtl/scdxt1_checker.sv]
// Port-level checker for the single-color DXT1 encoder, bound to its top level.
// Depends on scdxt1_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module scdxt1_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] endpoint_word,
	input wire logic [31:0] index_word,
	input wire logic [3:0]  blend_weight,
	input wire logic [3:0]  index_code
);

	`SCDXT1_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(endpoint_word) && $stable(blend_weight))
	`SCDXT1_ASSERT(a_backlog_only, clk, arst_n, !in_ready |-> out_valid)
	`SCDXT1_ASSERT_NEXT(a_backlog_drains, clk, arst_n, !in_ready && out_ready, in_ready)
	`SCDXT1_ASSERT(a_index_replicated, clk, arst_n, out_valid |-> index_word == {8{index_code}})
	`SCDXT1_ASSERT(a_code_legal, clk, arst_n, out_valid |-> (index_code == scdxt1_pkg::IDX_CODE_0 || index_code == scdxt1_pkg::IDX_CODE_1 || index_code == scdxt1_pkg::IDX_CODE_2 || index_code == scdxt1_pkg::IDX_CODE_3) && blend_weight <= scdxt1_pkg::WEIGHT_FULL)

endmodule

bind single_color_dxt1_block_encoder scdxt1_checker u_scdxt1_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (color.ready),
	.out_valid     (block.valid),
	.out_ready     (block.ready),
	.endpoint_word (block.endpoint_word),
	.index_word    (block.index_word),
	.blend_weight  (block.blend_weight),
	.index_code    (block.index_code)
);

`default_nettype wire
